// ===== sv/cdg_pkg.sv =====
// Shared types and constants for the masked central-difference gradient block.
// No dependencies; imported by the result queue and the top level.
package cdg_pkg;

	localparam int GRAD_BITS = 17;
	localparam int POS_BITS  = 11;
	localparam int CFG_BITS  = 12;

	localparam logic [1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_MASK_ON   = 2'd2;

	localparam logic [CFG_BITS-1:0] ROW_COUNT_RST = 12'd480;
	localparam logic [CFG_BITS-1:0] COL_COUNT_RST = 12'd640;
	localparam logic [CFG_BITS-1:0] MIN_DIM       = 12'd3;
	localparam logic [CFG_BITS-1:0] MAX_ROWS      = 12'd2048;

	localparam int RES_DEPTH = 8;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_LW    = RES_AW + 1;
	localparam logic [RES_LW-1:0] LEVEL_LIM_BUSY = RES_LW'(RES_DEPTH - 4);
	localparam logic [RES_LW-1:0] LEVEL_LIM_IDLE = RES_LW'(RES_DEPTH - 2);

	typedef struct packed {
		logic signed [GRAD_BITS-1:0] grad_u;
		logic signed [GRAD_BITS-1:0] grad_v;
		logic                        grad_valid;
		logic [POS_BITS-1:0]         row;
		logic [POS_BITS-1:0]         col;
		logic                        last;
	} res_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
		res_t res_a;
		res_t res_b;
	} push_t;

	typedef struct packed {
		logic [RES_LW-1:0] level;
	} fifo_stat_t;

endpackage

// ===== sv/cdg_line_store.sv =====
// Line store: one synchronous memory holding, per column, the pixel and mask of
// the two previous rows. One write port and two registered read ports.
module cdg_line_store #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 34
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== sv/cdg_res_fifo.sv =====
// Result queue: takes up to two results per cycle and hands out one per transfer.
// Depends on cdg_pkg for the result, push and status types.
module cdg_res_fifo import cdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output fifo_stat_t stat,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       head
);

	res_t              mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_LW-1:0] level_q;
	logic              pop;
	logic [RES_AW-1:0] wr_ptr_b;
	logic [RES_LW-1:0] push_cnt;

	assign pop      = res_valid && res_ready;
	assign wr_ptr_b = wr_ptr_q + RES_AW'(1);
	assign push_cnt = RES_LW'(push.push_a) + RES_LW'(push.push_b);

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem_q[wr_ptr_q] <= push.res_a;
		end
		if (push.push_b) begin
			mem_q[wr_ptr_b] <= push.res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[RES_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			level_q <= level_q + push_cnt - RES_LW'(pop);
		end
	end

	assign res_valid  = (level_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign stat.level = level_q;

endmodule

// ===== sv/central_difference_gradient_masked.sv =====
// Masked central-difference image gradient, top level.
// Depends on cdg_pkg, cdg_line_store and cdg_res_fifo.
//
// Usage:
// Pixels enter in raster order on the src channel (pixel, mask_in), one transfer
// per pixel. Results leave on the res channel, one transfer per result, in order.
// The result for pixel (r-1, c) is produced by the transfer of pixel (r, c); a
// pixel of the last row also produces its own zero border result right after.
// Row 0 produces no result. The flag last_of_run marks the last result of a pixel.
// Order: a result passes the pixel stage register and the result queue before it is offered.
// Throughput: one pixel per cycle while the result queue has room, limited by the
// single-result output port; on the last row, where each pixel gives two results,
// src_ready drops more often and input slows. Each pixel reads its column and the next
// one from the line store and writes its column back in the following cycle.
// Configuration (row_count, col_count, mask_on) is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Reset clears the position to (0, 0), restores the register defaults and
// empties the result queue; the line store needs no clearing pass.
// When the receiver stalls, results collect in an eight-entry queue and src_ready
// drops before it could overflow.
module central_difference_gradient_masked import cdg_pkg::*; #(
	parameter int MAX_COLS   = 2048,
	parameter int PIXEL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_ready,
	input  logic [PIXEL_BITS-1:0]       pixel,
	input  logic                        mask_in,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [GRAD_BITS-1:0] grad_u,
	output logic signed [GRAD_BITS-1:0] grad_v,
	output logic                        grad_valid,
	output logic [POS_BITS-1:0]         out_row,
	output logic [POS_BITS-1:0]         out_col,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [CFG_BITS-1:0]         cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int NW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
	localparam int WW = 2 * PIXEL_BITS + 2;
	localparam int DW = (PIXEL_BITS + 1 > GRAD_BITS) ? PIXEL_BITS + 1 : GRAD_BITS;

	logic [CFG_BITS-1:0] row_count_q;
	logic [CFG_BITS-1:0] col_count_q;
	logic                mask_on_q;
	logic [POS_BITS-1:0] row_q;
	logic [CW-1:0]       col_q;

	logic [CFG_BITS-1:0] nr;
	logic [NW-1:0]       nc;
	logic [NW-1:0]       col_count_x;
	logic                out_range;
	logic [POS_BITS-1:0] r0;
	logic [CW-1:0]       c0;
	logic [NW-1:0]       c_inc;
	logic [CFG_BITS-1:0] row_inc;
	logic                wrap_col;
	logic                accept;
	logic                m_eff;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  m_s1;
	logic [POS_BITS-1:0]   row_s1;
	logic [CW-1:0]         col_s1;
	logic                  has_res_s1;
	logic                  last_row_s1;
	logic                  interior_s1;
	logic [PIXEL_BITS-1:0] left_q;
	logic                  left_m_q;

	logic [WW-1:0]         rd_a;
	logic [WW-1:0]         rd_b;
	logic [PIXEL_BITS-1:0] top_pix;
	logic                  top_m;
	logic [PIXEL_BITS-1:0] mid_pix;
	logic                  mid_m;
	logic [PIXEL_BITS-1:0] right_pix;
	logic                  right_m;
	logic [DW-1:0]         du;
	logic [DW-1:0]         dv;

	push_t      push;
	fifo_stat_t stat;
	res_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			mask_on_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				REG_MASK_ON:   mask_on_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_count_q < MIN_DIM) begin
			nr = MIN_DIM;
		end else if (row_count_q > MAX_ROWS) begin
			nr = MAX_ROWS;
		end else begin
			nr = row_count_q;
		end
		col_count_x = NW'(col_count_q);
		if (col_count_x < NW'(MIN_DIM)) begin
			nc = NW'(MIN_DIM);
		end else if (col_count_x > NW'(MAX_COLS)) begin
			nc = NW'(MAX_COLS);
		end else begin
			nc = col_count_x;
		end
	end

	assign out_range = (CFG_BITS'(row_q) >= nr) || (NW'(col_q) >= nc);
	assign r0        = out_range ? '0 : row_q;
	assign c0        = out_range ? '0 : col_q;
	assign c_inc     = NW'(c0) + NW'(1);
	assign row_inc   = CFG_BITS'(r0) + CFG_BITS'(1);
	assign wrap_col  = (c_inc >= nc);
	assign accept    = src_valid && src_ready;
	assign m_eff     = mask_on_q ? mask_in : 1'b1;
	assign src_ready = valid_s1 ? (stat.level <= LEVEL_LIM_BUSY)
	                            : (stat.level <= LEVEL_LIM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (wrap_col) begin
				col_q <= '0;
				row_q <= (row_inc >= nr) ? '0 : row_inc[POS_BITS-1:0];
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel;
			m_s1        <= m_eff;
			row_s1      <= r0;
			col_s1      <= c0;
			has_res_s1  <= (r0 != '0);
			last_row_s1 <= (CFG_BITS'(r0) == nr - CFG_BITS'(1));
			interior_s1 <= (r0 >= POS_BITS'(2)) && (c0 != '0) && (c_inc < nc);
		end
		if (valid_s1) begin
			left_q   <= mid_pix;
			left_m_q <= mid_m;
		end
	end

	cdg_line_store #(
		.DEPTH (MAX_COLS),
		.WIDTH (WW)
	) u_line_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (c0),
		.rd_addr_b (c_inc[CW-1:0]),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.wr_en     (valid_s1),
		.wr_addr   (col_s1),
		.wr_data   ({mid_pix, mid_m, pix_s1, m_s1})
	);

	assign top_pix   = rd_a[WW-1 -: PIXEL_BITS];
	assign top_m     = rd_a[PIXEL_BITS+1];
	assign mid_pix   = rd_a[PIXEL_BITS:1];
	assign mid_m     = rd_a[0];
	assign right_pix = rd_b[PIXEL_BITS:1];
	assign right_m   = rd_b[0];

	assign du = DW'(right_pix) - DW'(left_q);
	assign dv = DW'(pix_s1) - DW'(top_pix);

	always_comb begin
		push.push_a           = valid_s1 && has_res_s1;
		push.push_b           = valid_s1 && last_row_s1;
		push.res_a.grad_u     = interior_s1 ? $signed(du[GRAD_BITS-1:0]) : '0;
		push.res_a.grad_v     = interior_s1 ? $signed(dv[GRAD_BITS-1:0]) : '0;
		push.res_a.grad_valid = interior_s1 && left_m_q && right_m && top_m && m_s1 && mid_m;
		push.res_a.row        = row_s1 - POS_BITS'(1);
		push.res_a.col        = POS_BITS'(col_s1);
		push.res_a.last       = !last_row_s1;
		push.res_b.grad_u     = '0;
		push.res_b.grad_v     = '0;
		push.res_b.grad_valid = 1'b0;
		push.res_b.row        = row_s1;
		push.res_b.col        = POS_BITS'(col_s1);
		push.res_b.last       = 1'b1;
	end

	cdg_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.head      (head)
	);

	assign grad_u      = head.grad_u;
	assign grad_v      = head.grad_v;
	assign grad_valid  = head.grad_valid;
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign last_of_run = head.last;

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> valid_s1)
		else $error("accepted pixel did not reach the line store stage");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level > LEVEL_LIM_IDLE |-> !src_ready)
		else $error("pixel accepted with the result queue nearly full");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> (NW'(col_q) < nc))
		else $error("column position left the frame after a transfer");

	a_last_row_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_row_s1 |-> has_res_s1)
		else $error("last row pixel without a result for the row above");

endmodule
